@@ sv/spq_pkg.sv @@
`timescale 1ns / 1ps
package spq_pkg;

	localparam int KEY_W = 32;
	localparam int PAYLOAD_W = 16;
	localparam int COUNT_W = 7;
	localparam int CAP_W = 7;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_EXTRACT = 1'b1;

	typedef struct packed {
		logic mode;
		logic signed [KEY_W-1:0] key;
		logic [PAYLOAD_W-1:0] payload;
	} spq_in_t;

	typedef struct packed {
		logic ok;
		logic [PAYLOAD_W-1:0] out_payload;
		logic signed [KEY_W-1:0] out_key;
		logic [COUNT_W-1:0] count;
	} spq_out_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [PAYLOAD_W-1:0] payload;
	} spq_entry_t;

	// Operation broadcast to every cell of the chain.
	typedef struct packed {
		logic ins;
		logic ext;
		spq_entry_t entry;
	} spq_ctl_t;

endpackage

@@ sv/spq_cell.sv @@
`timescale 1ns / 1ps
module spq_cell
	import spq_pkg::*;
(
	input  logic clk,
	input  spq_ctl_t ctl,
	input  logic occ,
	input  logic at_tail,
	input  logic prev_shift,
	input  spq_entry_t prev_entry,
	input  spq_entry_t next_entry,
	output spq_entry_t entry,
	output logic shift
);

	spq_entry_t entry_q;

	// Push right when the stored key is not below the new key.
	assign shift = occ && !($signed(entry_q.key) < $signed(ctl.entry.key));
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (prev_shift) begin
				entry_q <= prev_entry;
			end else if (shift || at_tail) begin
				entry_q <= ctl.entry;
			end
		end else if (ctl.ext) begin
			entry_q <= next_entry;
		end
	end

endmodule

@@ sv/sorted_priority_queue.sv @@
`timescale 1ns / 1ps
// Sorted min-priority queue built as a chain of DEPTH cells, slot 0 holding the minimum.
// The result beat is registered and appears in the cycle after the input beat is accepted.
// Throughput: one item per cycle unless stalled; each cell compares its key with the
// broadcast key and takes its left neighbor, new entry or right neighbor in one step.
// Reset (arst_n low, asynchronous): count clears to zero, capacity returns to 64,
// output register empties; cell contents are not cleared and are never read unset.
module sorted_priority_queue
	import spq_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  spq_in_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output spq_out_t out_data,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [CAP_W-1:0] cfg_data
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

	logic [CAP_W-1:0] cap_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_nxt;
	logic out_valid_q;
	spq_out_t out_q;

	logic accept;
	logic room;
	logic ins_go;
	logic ext_go;
	spq_ctl_t ctl;

	spq_entry_t cell_entry [DEPTH];
	logic [DEPTH-1:0] cell_shift;

	// Configuration is always taken; the user must send writes only while idle, which the block does not enforce.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	// Hold the input while a finished result still waits downstream; a result
	// taken this cycle frees the output register for the next beat.
	assign in_stall = out_valid_q && out_stall;
	assign accept = in_valid && !in_stall;

	// Refuse inserts at the capacity register or at the physical depth.
	assign room = (CMPW'(count_q) < CMPW'(cap_q)) && (count_q < CW'(DEPTH));
	assign ins_go = accept && (in_data.mode == MODE_INSERT) && room;
	assign ext_go = accept && (in_data.mode == MODE_EXTRACT) && (count_q != '0);

	assign ctl.ins = ins_go;
	assign ctl.ext = ext_go;
	assign ctl.entry.key = in_data.key;
	assign ctl.entry.payload = in_data.payload;

	always_comb begin
		count_nxt = count_q;
		if (ins_go) begin
			count_nxt = count_q + CW'(1);
		end else if (ext_go) begin
			count_nxt = count_q - CW'(1);
		end
	end

	// The chain: cell i is occupied below the count, and the tail slot takes
	// the new entry when nothing ahead of it has to move.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		spq_entry_t prev_e;
		spq_entry_t next_e;
		logic prev_s;

		if (i == 0) begin : g_head
			assign prev_e = '0;
			assign prev_s = 1'b0;
		end else begin : g_mid
			assign prev_e = cell_entry[i-1];
			assign prev_s = cell_shift[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_e = '0;
		end else begin : g_body
			assign next_e = cell_entry[i+1];
		end

		spq_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occ       (CW'(i) < count_q),
			.at_tail   (CW'(i) == count_q),
			.prev_shift(prev_s),
			.prev_entry(prev_e),
			.next_entry(next_e),
			.entry     (cell_entry[i]),
			.shift     (cell_shift[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture the result beat; an extract returns the head cell before it moves.
	always_ff @(posedge clk) begin
		if (accept) begin
			out_q.ok <= ins_go || ext_go;
			out_q.out_key <= ext_go ? cell_entry[0].key : '0;
			out_q.out_payload <= ext_go ? cell_entry[0].payload : '0;
			out_q.count <= COUNT_W'(count_nxt);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count_q))
		else $error("entry count moved without an accepted beat");

	a_empty_extract: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (in_data.mode == MODE_EXTRACT) && (count_q == '0)
		|=> out_valid && !out_data.ok && (out_data.out_key == '0))
		else $error("extract on empty queue reported an entry");

	a_full_insert: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (in_data.mode == MODE_INSERT) && !room |=> $stable(count_q))
		else $error("refused insert changed the count");
`endif

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
	import spq_pkg::*;

	localparam int QUEUE_DEPTH = 64;
	localparam int LONG_HOLD = 300;
	localparam int NUM_PHASES = 11;

	// Receiver stall patterns; the receiver picks a new one every so often.
	typedef enum logic [1:0] {
		RX_OPEN,
		RX_LIGHT,
		RX_HEAVY,
		RX_EVERY_THIRD
	} rx_pattern_e;

	// Shadow of the sorted queue: applies each accepted operation to its own copy of
	// the entries and queues the result beat the block must return for it.
	class min_queue_mirror #(int SLOTS = 64);
		logic signed [KEY_W-1:0] keys[SLOTS];
		logic [PAYLOAD_W-1:0] pays[SLOTS];
		int unsigned held;
		logic [CAP_W-1:0] cap;
		spq_out_t due_results[$];
		int errors;
		int ins_ok, ins_refused, ext_ok, ext_empty, peak;

		function new();
			held = 0;
			cap = CAP_RESET;
			errors = 0;
			ins_ok = 0;
			ins_refused = 0;
			ext_ok = 0;
			ext_empty = 0;
			peak = 0;
		endfunction

		function void set_capacity(logic [CAP_W-1:0] v);
			cap = v;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		function void apply_op(spq_in_t beat);
			spq_out_t r;
			int pos;
			r = '0;
			if (beat.mode == MODE_INSERT) begin
				if (held < cap && held < SLOTS) begin
					// place ahead of the first key that is not smaller: newest wins ties
					pos = 0;
					while (pos < held && keys[pos] < beat.key)
						pos++;
					for (int i = held; i > pos; i--) begin
						keys[i] = keys[i-1];
						pays[i] = pays[i-1];
					end
					keys[pos] = beat.key;
					pays[pos] = beat.payload;
					held++;
					r.ok = 1'b1;
					ins_ok++;
				end else begin
					ins_refused++;
				end
			end else if (held > 0) begin
				r.ok = 1'b1;
				r.out_key = keys[0];
				r.out_payload = pays[0];
				for (int i = 1; i < held; i++) begin
					keys[i-1] = keys[i];
					pays[i-1] = pays[i];
				end
				held--;
				ext_ok++;
			end else begin
				ext_empty++;
			end
			if (held > peak)
				peak = held;
			r.count = COUNT_W'(held);
			due_results.push_back(r);
		endfunction

		function void compare_result(spq_out_t got);
			spq_out_t want;
			if (due_results.size() == 0) begin
				$error("result beat with nothing expected: ok=%0b key=%0d payload=%0d count=%0d",
					got.ok, got.out_key, got.out_payload, got.count);
				errors++;
				return;
			end
			want = due_results.pop_front();
			if (got.ok !== want.ok) begin
				$error("ok: expected %0b, actual %0b", want.ok, got.ok);
				errors++;
			end
			if (got.out_payload !== want.out_payload) begin
				$error("out_payload: expected %0d, actual %0d",
					want.out_payload, got.out_payload);
				errors++;
			end
			if (got.out_key !== want.out_key) begin
				$error("out_key: expected %0d, actual %0d", want.out_key, got.out_key);
				errors++;
			end
			if (got.count !== want.count) begin
				$error("count: expected %0d, actual %0d", want.count, got.count);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	spq_in_t in_data;
	logic out_valid;
	logic out_stall;
	spq_out_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [CAP_W-1:0] cfg_data;

	min_queue_mirror #(QUEUE_DEPTH) mirror;
	int burst_left;
	int cfg_writes;
	int hold_offs;
	bit hold_off_req;

	// Plan of the random part: capacity (-1 picks one at random), percent of inserts,
	// number of beats. The queue is not emptied between phases, so a low capacity after
	// a full phase leaves the count above the limit.
	int phase_cap[NUM_PHASES] = '{127, 64, 5, 0, 65, 64, 1, 33, 2, 64, -1};
	int phase_ins[NUM_PHASES] = '{80, 60, 50, 30, 85, 50, 50, 60, 50, 45, 55};
	int phase_len[NUM_PHASES] = '{175, 175, 160, 110, 175, 175, 110, 175, 110, 175, 160};

	sorted_priority_queue #(
		.DEPTH(QUEUE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// Check every result beat the receiver takes, at the rising edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			mirror.compare_result(out_data);
	end

	// Receiver: stall on a pattern of its own, and on request hold off for a long
	// stretch so the block backs up into its input.
	initial begin
		rx_pattern_e pattern;
		int rx_cycle;
		pattern = RX_OPEN;
		rx_cycle = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_offs++;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
			end
			if (rx_cycle % 97 == 0)
				pattern = rx_pattern_e'($urandom_range(0, 3));
			rx_cycle++;
			case (pattern)
				RX_OPEN: begin
					out_stall <= 1'b0;
				end
				RX_LIGHT: begin
					out_stall <= ($urandom_range(0, 99) < 25);
				end
				RX_HEAVY: begin
					out_stall <= ($urandom_range(0, 99) < 70);
				end
				default: begin
					out_stall <= (rx_cycle % 3 == 0);
				end
			endcase
		end
	end

	function automatic spq_in_t make_op(logic mode, logic signed [KEY_W-1:0] key,
			logic [PAYLOAD_W-1:0] payload);
		spq_in_t beat;
		beat.mode = mode;
		beat.key = key;
		beat.payload = payload;
		return beat;
	endfunction

	// Favor a few small keys so equal keys pile up, plus the extremes and full range.
	function automatic logic signed [KEY_W-1:0] pick_key();
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2, 3, 4: return $urandom_range(0, 8) - 4;
			5: return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
			default: return $urandom;
		endcase
	endfunction

	// Extract beats carry random key and payload too; the block must ignore them.
	function automatic spq_in_t random_op(int ins_pct);
		logic mode;
		mode = ($urandom_range(0, 99) < ins_pct) ? MODE_INSERT : MODE_EXTRACT;
		return make_op(mode, pick_key(), PAYLOAD_W'($urandom_range(0, 16'hFFFF)));
	endfunction

	// Offer one beat, called at a falling edge; returns at the falling edge after it
	// was taken. Bursts of random length are separated by random gaps.
	task automatic send_op(input spq_in_t beat);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data <= beat;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		mirror.apply_op(beat);
		@(negedge clk);
	endtask

	// Drop valid and wait until every expected result has come back.
	task automatic drain_queue();
		in_valid <= 1'b0;
		while (mirror.pending() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	// Write the capacity register with the block idle.
	task automatic write_capacity(input logic [CAP_W-1:0] v);
		drain_queue();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		mirror.set_capacity(v);
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int cap_v;
		mirror = new();
		burst_left = 0;
		cfg_writes = 0;
		hold_offs = 0;
		hold_off_req = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Empty extract, then the key extremes, a tie on zero, minus one and the signed integer key 0x10000.
		send_op(make_op(MODE_EXTRACT, 32'sh1234_5678, 16'hABCD));
		send_op(make_op(MODE_INSERT, 32'sh7FFF_FFFF, 16'hFFFF));
		send_op(make_op(MODE_INSERT, 32'sh8000_0000, 16'h0000));
		send_op(make_op(MODE_INSERT, 32'sh0000_0000, 16'h1111));
		send_op(make_op(MODE_INSERT, 32'sh0000_0000, 16'h2222));
		send_op(make_op(MODE_INSERT, -32'sd1, 16'h3333));
		send_op(make_op(MODE_INSERT, 32'sh0001_0000, 16'h4444));
		repeat (7) send_op(make_op(MODE_EXTRACT, 32'shFFFF_FFFF, 16'hFFFF));

		// Full at a small capacity, then capacity below the count, then zero.
		write_capacity(7'd2);
		send_op(make_op(MODE_INSERT, 32'sh0000_0005, 16'h0505));
		send_op(make_op(MODE_INSERT, 32'sh0000_0003, 16'h0303));
		send_op(make_op(MODE_INSERT, 32'sh0000_0001, 16'h0101));
		write_capacity(7'd1);
		send_op(make_op(MODE_INSERT, 32'sh0000_0002, 16'h0202));
		send_op(make_op(MODE_EXTRACT, 32'sh0, 16'h0));
		write_capacity(7'd0);
		send_op(make_op(MODE_INSERT, 32'sh0000_0004, 16'h0404));
		send_op(make_op(MODE_EXTRACT, 32'sh0, 16'h0));
		send_op(make_op(MODE_EXTRACT, 32'sh0, 16'h0));

		// Random phases; two of them start with a long receiver hold-off.
		for (int p = 0; p < NUM_PHASES; p++) begin
			cap_v = (phase_cap[p] < 0) ? $urandom_range(0, 127) : phase_cap[p];
			write_capacity(cap_v[CAP_W-1:0]);
			if (p == 5 || p == 9)
				hold_off_req = 1'b1;
			repeat (phase_len[p])
				send_op(random_op(phase_ins[p]));
		end

		drain_queue();
		repeat (4) @(negedge clk);
		$display("Covered %0d inserts (%0d refused) and %0d extracts (%0d on empty), %s",
			mirror.ins_ok + mirror.ins_refused, mirror.ins_refused,
			mirror.ext_ok + mirror.ext_empty, mirror.ext_empty,
			$sformatf("peak %0d of %0d.", mirror.peak, QUEUE_DEPTH));
		$display("Capacity written %0d times across 0 to 127; %0d long receiver hold-offs.",
			cfg_writes, hold_offs);
		if (mirror.errors == 0 && mirror.pending() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Give up well past the slowest legal run.
	initial begin
		#1_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
